>>> src/sdf_pkg.sv
// Shared types and constants for the signed decimal formatter.
// No dependencies; used by sdf_bcd_conv and signed_decimal_formatter.
package sdf_pkg;

  localparam int MAG_W      = 64;               // magnitude width
  localparam int BIT_CNT_W  = $clog2(MAG_W);    // shift counter width
  localparam int NUM_DIGITS = 20;               // decimal digits of a 64-bit magnitude
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int ND_W       = $clog2(NUM_DIGITS + 1);
  localparam int LEN_W      = 8;                // holds any conversion length (<= 127)

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [ND_W-1:0]  nd_t;

  // converter status toward the formatter
  typedef struct packed {
    logic done;   // one-cycle pulse, digits and digit count valid
    nd_t  nd;     // significant digit count, at least one
  } conv_stat_t;

endpackage

>>> src/sdf_bcd_conv.sv
// Bit-serial binary to BCD converter (shift-and-add-3) with leading-zero strip.
// Depends on sdf_pkg.
module sdf_bcd_conv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sdf_pkg::mag_t      mag,
  output sdf_pkg::bcd_t      digits,
  output sdf_pkg::conv_stat_t stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_NORM  = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  sdf_pkg::mag_t                   mag_r, mag_nxt;
  sdf_pkg::bcd_t                   bcd_r, bcd_nxt, adj;
  logic [sdf_pkg::BIT_CNT_W-1:0]   cnt_r, cnt_nxt;
  sdf_pkg::nd_t                    nd_r, nd_nxt;
  logic                            done_r, done_nxt;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    nd_nxt    = nd_r;
    done_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mag_nxt   = mag;
          bcd_nxt   = '0;
          cnt_nxt   = '1;
          nd_nxt    = sdf_pkg::nd_t'(sdf_pkg::NUM_DIGITS);
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bcd_nxt = {adj[sdf_pkg::BCD_W-2:0], mag_r[sdf_pkg::MAG_W-1]};
        mag_nxt = {mag_r[sdf_pkg::MAG_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (nd_r > sdf_pkg::nd_t'(1) && bcd_r[sdf_pkg::BCD_W-1 -: 4] == 4'd0) begin
          bcd_nxt = {bcd_r[sdf_pkg::BCD_W-5:0], 4'd0};
          nd_nxt  = nd_r - 1'b1;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    nd_r  <= nd_nxt;
  end

  assign digits    = bcd_r;
  assign stat.done = done_r;
  assign stat.nd   = nd_r;

endmodule

>>> src/signed_decimal_formatter.sv
// Signed decimal formatter: one printf %d conversion per request, one character per cycle out
// while the output is not stalled. After accept the converter shifts the magnitude into BCD,
// one bit-serial shift per magnitude bit, strips leading zeros one digit at a time and signals
// done; the formatter then captures the digits, lays out the characters and loads the output.
// A new request is taken only in idle, once the last character has been loaded to the output.
// Sync active-low reset returns to idle and empties the output register; the last character
// may still wait in the output while the next request enters, nothing is lost or repeated.
module signed_decimal_formatter #(
  parameter int MAX_OUTPUT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_length_mode,
  input  logic [6:0]  in_min_width,
  input  logic [6:0]  in_precision,
  input  logic        in_left_align,
  input  logic        in_zero_fill,
  input  logic        in_force_plus,
  input  logic        in_space_sign,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_out,
  output logic        out_last_char
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [1:0] LEN_8  = 2'd0;
  localparam logic [1:0] LEN_16 = 2'd1;
  localparam logic [1:0] LEN_32 = 2'd2;
  localparam logic [1:0] LEN_64 = 2'd3;

  localparam sdf_pkg::len_t MAX_LEN = sdf_pkg::len_t'(MAX_OUTPUT);

  logic [1:0]          state_r, state_nxt;
  logic                accept;

  // request fields kept for the layout step
  logic [6:0]          fw_r, prec_r;
  logic                left_r, zero_r, plus_r, space_r, neg_r, mag_zero_r;

  // layout: segment boundaries along the character position
  sdf_pkg::len_t       b1_r, b2_r, b3_r, b4_r, cnt_r, pos_r;
  sdf_pkg::len_t       b1_nxt, b2_nxt, b3_nxt, b4_nxt, cnt_nxt;
  logic [7:0]          sign_ch_r, sign_ch_nxt;
  sdf_pkg::bcd_t       dig_r;

  // output register
  logic                out_valid_r;
  logic [7:0]          out_char_r, char_nxt;
  logic                out_last_r;
  logic                load;
  logic                last_pos;

  // sign extension and magnitude
  logic [63:0]         ext;
  sdf_pkg::mag_t       mag;

  sdf_pkg::bcd_t       conv_digits;
  sdf_pkg::conv_stat_t conv_stat;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    case (in_length_mode)
      LEN_8:   ext = {{56{in_value[7]}}, in_value[7:0]};
      LEN_16:  ext = {{48{in_value[15]}}, in_value[15:0]};
      LEN_32:  ext = {{32{in_value[31]}}, in_value[31:0]};
      LEN_64:  ext = in_value;
      default: ext = in_value;
    endcase
    mag = ext[63] ? (64'd0 - ext) : ext;
  end

  sdf_bcd_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .mag    (mag),
    .digits (conv_digits),
    .stat   (conv_stat)
  );

  // Layout: work out how many of each kind of character come out.
  // Zero with zero precision prints no digits.
  logic                prec_none, zf;
  sdf_pkg::len_t       nd, prec, fw, sign_len, zeros, body, pad, len, lead_sp, zfill;

  always_comb begin
    prec_none = prec_r[6];
    prec      = sdf_pkg::len_t'(prec_r[5:0]);
    fw        = sdf_pkg::len_t'(fw_r);
    if (mag_zero_r && !prec_none && prec == '0) begin
      nd = '0;
    end else begin
      nd = sdf_pkg::len_t'(conv_stat.nd);
    end
    if (neg_r) begin
      sign_ch_nxt = sdf_pkg::CHAR_MINUS;
    end else if (plus_r) begin
      sign_ch_nxt = sdf_pkg::CHAR_PLUS;
    end else begin
      sign_ch_nxt = sdf_pkg::CHAR_SPACE;
    end
    sign_len = (neg_r || plus_r || space_r) ? sdf_pkg::len_t'(1) : '0;
    zeros    = (!prec_none && prec > nd) ? prec - nd : '0;
    body     = sign_len + zeros + nd;
    pad      = (fw > body) ? fw - body : '0;
    len      = pad + body;
    // zero flag pads after the sign only when no precision and right-aligned
    zf       = prec_none && zero_r && !left_r;
    lead_sp  = (!left_r && !zf) ? pad : '0;
    zfill    = (zf ? pad : '0) + zeros;
    b1_nxt   = lead_sp;
    b2_nxt   = b1_nxt + sign_len;
    b3_nxt   = b2_nxt + zfill;
    b4_nxt   = b3_nxt + nd;
    cnt_nxt  = (len > MAX_LEN) ? MAX_LEN : len;
  end

  // character at the current position
  always_comb begin
    if (pos_r < b1_r) begin
      char_nxt = sdf_pkg::CHAR_SPACE;
    end else if (pos_r < b2_r) begin
      char_nxt = sign_ch_r;
    end else if (pos_r < b3_r) begin
      char_nxt = sdf_pkg::CHAR_ZERO;
    end else if (pos_r < b4_r) begin
      char_nxt = sdf_pkg::CHAR_ZERO | {4'd0, dig_r[sdf_pkg::BCD_W-1 -: 4]};
    end else begin
      char_nxt = sdf_pkg::CHAR_SPACE;
    end
  end

  assign load     = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign last_pos = (pos_r == cnt_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CONV;
      ST_CONV:  if (conv_stat.done) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = (cnt_nxt == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT:  if (load && last_pos) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fw_r       <= in_min_width;
      prec_r     <= in_precision;
      left_r     <= in_left_align;
      zero_r     <= in_zero_fill;
      plus_r     <= in_force_plus;
      space_r    <= in_space_sign;
      neg_r      <= ext[63];
      mag_zero_r <= (ext == 64'd0);
    end
    if (state_r == ST_CONV && conv_stat.done) begin
      dig_r <= conv_digits;
    end
    if (state_r == ST_SETUP) begin
      b1_r      <= b1_nxt;
      b2_r      <= b2_nxt;
      b3_r      <= b3_nxt;
      b4_r      <= b4_nxt;
      cnt_r     <= cnt_nxt;
      sign_ch_r <= sign_ch_nxt;
      pos_r     <= '0;
    end
    if (load) begin
      out_char_r <= char_nxt;
      out_last_r <= last_pos;
      pos_r      <= pos_r + 1'b1;
      // digits leave most significant first
      if (pos_r >= b3_r && pos_r < b4_r) begin
        dig_r <= {dig_r[sdf_pkg::BCD_W-5:0], 4'd0};
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

endmodule

>>> src/sdf_checker.sv
// Port-level checks for signed_decimal_formatter, attached by bind.
// Depends on the top level's ports only.
module sdf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic       out_last_char
);

  // stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_out) && $stable(out_last_char))
    else $error("output changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // a new request cannot enter while a conversion is mid-stream
  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |-> !in_ready)
    else $error("ready while characters remain");

  // a shown character is fully defined
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_char_out) && !$isunknown(out_last_char))
    else $error("unknown character bits");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_out  (out_char_out),
  .out_last_char (out_last_char)
);
